/* design/utf8ws_pkg.sv */
// Package for the UTF-8 word splitter: state and result types, result queue
// constants, and the byte classification and lowercasing functions.
// No dependencies.
package utf8ws_pkg;

    // Lead byte of the only two-byte sequence that is accepted
    localparam logic [7:0] LeadC3      = 8'hC3;
    localparam logic [7:0] ContLow     = 8'h80;
    localparam logic [7:0] ContHigh    = 8'hBF;
    localparam logic [2:0] SkipMax     = 3'd7;

    // Result queue sizing
    localparam int FifoDepth = 4;
    localparam int PtrW      = $clog2(FifoDepth);
    localparam int CntW      = $clog2(FifoDepth + 1);

    typedef struct packed {
        logic [7:0]  held_byte;
        logic        held_valid;
        logic [7:0]  previous_byte;
        logic        word_open;
        logic        skip_active;
        logic [2:0]  skip_count;
        logic [15:0] words_done;
        logic [7:0]  last_raw;
    } state_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        word_end;
        logic        warning;
        logic [15:0] word_number;
        logic        last_result;
    } result_t;

    typedef result_t [1:0] result_pair_t;

    // Gap bytes: space ? ! " ' # % * & ( ) = , ; . _ LF CR TAB /
    function automatic logic is_gap(input logic [7:0] c);
        logic hit;
        case (c)
            8'h20, 8'h3F, 8'h21, 8'h22, 8'h27, 8'h23, 8'h25, 8'h2A, 8'h26, 8'h28,
            8'h29, 8'h3D, 8'h2C, 8'h3B, 8'h2E, 8'h5F, 8'h0A, 8'h0D, 8'h09,
            8'h2F: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // ASCII capitals, and Latin-1 capitals after a 0xC3 lead (multiplication
    // sign excluded), move up by 0x20
    function automatic logic [7:0] lower(input logic [7:0] c, input logic [7:0] prior);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end else if (prior == LeadC3 && c >= 8'h80 && c <= 8'h9E && c != 8'h97) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

/* design/utf8ws_step.sv */
// Next-state and result logic for one input byte of the word splitter.
// Depends on utf8ws_pkg.
module utf8ws_step (
    input  utf8ws_pkg::state_t       cur_state,
    input  logic [7:0]               in_byte,
    input  logic                     line_end,
    output utf8ws_pkg::state_t       nxt_state,
    output utf8ws_pkg::result_pair_t results,
    output logic [1:0]               res_count
);
    import utf8ws_pkg::*;

    logic [7:0] c;
    logic       consumed;
    logic       warn;
    logic       in_seq;
    logic [2:0] skip_inc;
    logic       body_hit;
    logic       flush_hit;
    result_t    body_res;
    result_t    flush_res;
    state_t     st;

    always_comb begin
        st        = cur_state;
        c         = lower(in_byte, cur_state.last_raw);
        st.last_raw = in_byte;
        warn      = 1'b0;
        consumed  = 1'b0;
        body_hit  = 1'b0;
        body_res  = '0;
        flush_res = '0;
        skip_inc  = cur_state.skip_count + 3'd1;

        // Consume continuation bytes of a long sequence
        if (cur_state.skip_active) begin
            if (c[7] && cur_state.skip_count < SkipMax) begin
                consumed = 1'b1;
                if (skip_inc >= SkipMax) begin
                    st.skip_active = 1'b0;
                    st.skip_count  = '0;
                end else begin
                    st.skip_count = skip_inc;
                end
            end else begin
                st.skip_active = 1'b0;
                st.skip_count  = '0;
            end
        end

        in_seq = (cur_state.previous_byte[7:5] == 3'b110);

        if (!consumed) begin
            if (c[7:5] == 3'b111) begin
                // Start of a three- or four-byte sequence: warn and skip
                warn                = 1'b1;
                body_hit            = 1'b1;
                body_res.warning    = 1'b1;
                body_res.word_number = st.words_done;
                st.skip_active      = 1'b1;
                st.skip_count       = 3'd1;
                st.previous_byte    = '0;
            end else if (in_seq && (cur_state.previous_byte != LeadC3
                                    || c < ContLow || c > ContHigh)) begin
                // Bad two-byte sequence: drop the held lead and this byte
                warn                = 1'b1;
                body_hit            = 1'b1;
                body_res.warning    = 1'b1;
                body_res.word_number = st.words_done;
                st.held_valid       = 1'b0;
                st.held_byte        = '0;
                st.previous_byte    = '0;
            end else if (in_seq || !is_gap(c)) begin
                // Word byte: release the held one, hold this one
                if (st.held_valid) begin
                    body_hit             = 1'b1;
                    body_res.out_byte    = st.held_byte;
                    body_res.byte_valid  = 1'b1;
                    body_res.word_number = st.words_done;
                    st.word_open         = 1'b1;
                end
                st.held_byte     = c;
                st.held_valid    = 1'b1;
                st.previous_byte = c;
            end else if (st.held_valid || st.word_open) begin
                // Gap closes the open word
                st.words_done        = sat_inc(st.words_done);
                body_hit             = 1'b1;
                body_res.out_byte    = st.held_valid ? st.held_byte : 8'h00;
                body_res.byte_valid  = st.held_valid;
                body_res.word_end    = 1'b1;
                body_res.word_number = st.words_done;
                st.held_valid        = 1'b0;
                st.held_byte         = '0;
                st.word_open         = 1'b0;
                st.previous_byte     = '0;
            end
        end

        // Flush the word at line end, then return to reset state
        flush_hit = line_end && (st.held_valid || st.word_open);
        flush_res.out_byte    = st.held_valid ? st.held_byte : 8'h00;
        flush_res.byte_valid  = st.held_valid;
        flush_res.word_end    = 1'b1;
        flush_res.warning     = warn;
        flush_res.word_number = sat_inc(st.words_done);
        flush_res.last_result = 1'b1;
        if (line_end) begin
            st = '0;
        end

        body_res.last_result = !flush_hit;
        nxt_state  = st;
        results[0] = body_hit ? body_res : flush_res;
        results[1] = flush_res;
        res_count  = {1'b0, body_hit} + {1'b0, flush_hit};
    end

endmodule

/* design/utf8_word_splitter_core.sv */
// Top level of the UTF-8 word splitter: state register, step logic and a
// small result queue. Depends on utf8ws_pkg and utf8ws_step.
//
// Takes one raw byte per word on the s_ side and returns lowercased word
// bytes on the m_ side, each tagged with word-end, warning and a running word
// count. A byte is accepted every cycle while the result queue (4 entries)
// holds at most 2 results; each result is registered in the queue before it
// appears on the m_ side. Most bytes give zero or one result, so the stream
// runs at one byte per cycle while the output side keeps up; a line-end byte
// that also releases a word byte, or warns inside a word, gives two results,
// which the queue absorbs. No clearing pass is needed after reset.
module utf8_word_splitter_core (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [7:0] in_byte
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,     // line_end
    // m_tdata: [7:0] out_byte, [23:8] word_number
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic [2:0]  m_tuser,     // [0] byte_valid, [1] warning, [2] last_result
    output logic        m_tlast      // word_end
);
    import utf8ws_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    result_pair_t      results;
    logic [1:0]        res_count;
    result_t           fifo_reg [FifoDepth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [CntW-1:0]   count_reg;
    logic [PtrW-1:0]   wr_ptr_plus1;
    logic              in_acc;
    logic              out_pop;
    result_t           head;

    utf8ws_step u_step (
        .cur_state (state_reg),
        .in_byte   (s_tdata),
        .line_end  (s_tlast),
        .nxt_state (state_next),
        .results   (results),
        .res_count (res_count)
    );

    assign s_tready     = (count_reg <= CntW'(FifoDepth - 2));
    assign in_acc       = s_tvalid && s_tready;
    assign out_pop      = m_tvalid && m_tready;
    assign wr_ptr_plus1 = wr_ptr_reg + PtrW'(1);

    // Advance the splitter state on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (in_acc) begin
            state_reg <= state_next;
        end
    end

    // Push up to two results into the queue
    always_ff @(posedge aclk) begin
        for (int i = 0; i < FifoDepth; i++) begin
            if (in_acc && res_count != 2'd0 && wr_ptr_reg == PtrW'(i)) begin
                fifo_reg[i] <= results[0];
            end else if (in_acc && res_count == 2'd2 && wr_ptr_plus1 == PtrW'(i)) begin
                fifo_reg[i] <= results[1];
            end
        end
    end

    // Track queue pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (in_acc) begin
                wr_ptr_reg <= wr_ptr_reg + PtrW'(res_count);
            end
            if (out_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
            count_reg <= count_reg + (in_acc ? CntW'(res_count) : CntW'(0))
                         - (out_pop ? CntW'(1) : CntW'(0));
        end
    end

    // Present the queue head
    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {head.word_number, head.out_byte};
    assign m_tuser  = {head.last_result, head.warning, head.byte_valid};
    assign m_tlast  = head.word_end;

    // Queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(FifoDepth))
        else $error("result queue overflow");

    // Line end returns the splitter to its reset state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_tlast) |=> (state_reg.words_done == '0 && !state_reg.held_valid
                                 && !state_reg.word_open && !state_reg.skip_active))
        else $error("state not cleared after line end");

    // Draining the last queued result with nothing pushed empties the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_pop && !in_acc && count_reg == CntW'(1)) |=> !m_tvalid)
        else $error("output valid after queue drained");

endmodule
